FILE: rtl/luiwd_pkg.sv
// shared constants, types and codes for the least-used idle worker dispatcher
package luiwd_pkg;

  localparam int NUM_WORKERS_DEF = 16;
  localparam int ACT_W           = 5;
  localparam int IDX_OUT_W       = 4;
  localparam int COUNT_W         = 32;

  localparam logic [ACT_W-1:0]   ACT_RESET = ACT_W'(16);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic OP_DISPATCH = 1'b0;
  localparam logic OP_RELEASE  = 1'b1;

  typedef enum logic [1:0] {
    ALU_LE  = 2'b01,
    ALU_INC = 2'b10
  } alu_op_t;

  typedef struct packed {
    logic                 granted;
    logic [IDX_OUT_W-1:0] chosen_index;
    logic [COUNT_W-1:0]   new_count;
  } res_t;

endpackage

FILE: rtl/luiwd_if.sv
// request and response channel interfaces
interface luiwd_req_if;
  import luiwd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [IDX_OUT_W-1:0] release_index;
  modport source(output valid, output op, output release_index, input ready);
  modport sink(input valid, input op, input release_index, output ready);
endinterface

interface luiwd_rsp_if;
  import luiwd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 granted;
  logic [IDX_OUT_W-1:0] chosen_index;
  logic [COUNT_W-1:0]   new_count;
  modport source(output valid, output granted, output chosen_index, output new_count,
                 input ready);
  modport sink(input valid, input granted, input chosen_index, input new_count,
               output ready);
endinterface

FILE: rtl/luiwd_alu.sv
// shared compare / saturating increment unit
module luiwd_alu (
  input  luiwd_pkg::alu_op_t                op,
  input  logic [luiwd_pkg::COUNT_W-1:0]     a,
  input  logic [luiwd_pkg::COUNT_W-1:0]     b,
  output logic [luiwd_pkg::COUNT_W-1:0]     y,
  output logic                              le
);
  import luiwd_pkg::*;

  always_comb begin
    le = (a <= b);
    case (op)
      ALU_INC: y = (a == COUNT_MAX) ? a : a + COUNT_W'(1);
      ALU_LE:  y = a;
      default: y = a;
    endcase
  end
endmodule

FILE: rtl/luiwd_seq.sv
// scan sequencer with worker state storage
module luiwd_seq #(
  parameter int NUM_WORKERS = luiwd_pkg::NUM_WORKERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          op,
  input  logic [luiwd_pkg::IDX_OUT_W-1:0] rel,
  input  logic [luiwd_pkg::ACT_W-1:0]   active,
  input  logic                          out_free,
  output logic                          idle,
  output logic                          push,
  output luiwd_pkg::res_t               res
);
  import luiwd_pkg::*;

  localparam int IDX_W  = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int CNTR_W = $clog2(NUM_WORKERS + 1);
  localparam int LIM_W  = (CNTR_W > ACT_W) ? CNTR_W : ACT_W;
  localparam logic [LIM_W-1:0] NW_L = LIM_W'(NUM_WORKERS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t               state;
  logic [LIM_W-1:0]     idx;
  logic [LIM_W-1:0]     limit;
  logic                 pend;
  logic [IDX_W-1:0]     pidx;
  logic                 pbusy;
  logic                 pvalid;
  logic [COUNT_W-1:0]   rdata;
  logic                 found;
  logic [IDX_W-1:0]     pick;
  logic [COUNT_W-1:0]   best;
  logic                 is_rel;
  logic [NUM_WORKERS-1:0] busy;
  logic [NUM_WORKERS-1:0] cvalid;
  logic [COUNT_W-1:0]   mem [NUM_WORKERS];

  logic [LIM_W-1:0]     act_l;
  logic [LIM_W-1:0]     rel_l;
  logic [COUNT_W-1:0]   cand;
  logic [COUNT_W-1:0]   alu_y;
  logic                 alu_le;
  alu_op_t              alu_op;
  logic                 take;
  logic                 issue;
  logic                 grant;
  logic [IDX_W+IDX_OUT_W-1:0] pick_ext;

  assign act_l  = LIM_W'(active);
  assign rel_l  = LIM_W'(rel);
  assign cand   = pvalid ? rdata : '0;
  assign alu_op = (state == S_DONE) ? ALU_INC : ALU_LE;
  assign take   = pend && !pbusy && (!found || alu_le);
  assign issue  = (state == S_SCAN) && (idx < limit);
  assign grant  = !is_rel && found;
  assign idle   = (state == S_IDLE);
  assign push   = (state == S_DONE) && out_free;

  luiwd_alu u_alu (
    .op (alu_op),
    .a  ((state == S_DONE) ? best : cand),
    .b  (best),
    .y  (alu_y),
    .le (alu_le)
  );

  always_comb begin
    pick_ext         = (IDX_W + IDX_OUT_W)'(pick);
    res.granted      = grant;
    res.chosen_index = grant ? pick_ext[IDX_OUT_W-1:0] : '0;
    res.new_count    = grant ? alu_y : '0;
  end

  // count store: read during scan, written back on grant
  always_ff @(posedge clk) begin
    if (issue) begin
      rdata <= mem[idx[IDX_W-1:0]];
    end
    if (push && grant) begin
      mem[pick] <= alu_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      busy   <= '0;
      cvalid <= '0;
      pend   <= 1'b0;
      found  <= 1'b0;
      is_rel <= 1'b0;
      idx    <= '0;
      limit  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            if (op == OP_RELEASE) begin
              if (rel_l < NW_L) begin
                busy[rel_l[IDX_W-1:0]] <= 1'b0;
              end
              is_rel <= 1'b1;
              state  <= S_DONE;
            end else begin
              is_rel <= 1'b0;
              idx    <= '0;
              pend   <= 1'b0;
              found  <= 1'b0;
              limit  <= (act_l > NW_L) ? NW_L : act_l;
              state  <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // compare the entry read last cycle while the next one is read
          if (take) begin
            found <= 1'b1;
            best  <= cand;
            pick  <= pidx;
          end
          if (issue) begin
            pend   <= 1'b1;
            pidx   <= idx[IDX_W-1:0];
            pbusy  <= busy[idx[IDX_W-1:0]];
            pvalid <= cvalid[idx[IDX_W-1:0]];
            idx    <= idx + LIM_W'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            if (grant) begin
              busy[pick]   <= 1'b1;
              cvalid[pick] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

FILE: rtl/least_used_idle_worker_dispatch_top.sv
// least-used idle worker dispatcher: one request at a time over a sequential scan
// dispatch: the response follows a sequential scan over min(active_workers, NUM_WORKERS) workers,
//   the scan reading one use count per cycle from the count store
// release: no scan; the sequencer goes from idle to done, and the response register loads from there
// next request taken the cycle after the response loads; the sequencer waits in its done state
//   while the previous response is not taken; rst clears busy flags and count valid flags
module least_used_idle_worker_dispatch_top #(
  parameter int NUM_WORKERS = luiwd_pkg::NUM_WORKERS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [luiwd_pkg::ACT_W-1:0]  cfg_wdata,
  luiwd_req_if.sink                    req,
  luiwd_rsp_if.source                  rsp
);
  import luiwd_pkg::*;

  logic [ACT_W-1:0] active_workers;
  logic             idle;
  logic             push;
  logic             out_free;
  res_t             res;

  assign req.ready = idle;
  assign out_free  = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_workers <= ACT_RESET;
    end else if (cfg_we) begin
      active_workers <= cfg_wdata;
    end
  end

  luiwd_seq #(
    .NUM_WORKERS (NUM_WORKERS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (req.valid && req.ready),
    .op       (req.op),
    .rel      (req.release_index),
    .active   (active_workers),
    .out_free (out_free),
    .idle     (idle),
    .push     (push),
    .res      (res)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (push) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rsp.granted      <= res.granted;
      rsp.chosen_index <= res.chosen_index;
      rsp.new_count    <= res.new_count;
    end
  end
endmodule

FILE: rtl/luiwd_chk.sv
// port-level checks for the dispatcher, bound to the top level
module luiwd_chk (
  input logic         clk,
  input logic         rst,
  luiwd_req_if.sink   req,
  luiwd_rsp_if.source rsp
);
  import luiwd_pkg::*;

  // one request in flight: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while previous one still in flight");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> rsp.valid)
    else $error("response dropped before it was taken");

  a_no_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.granted) |-> (rsp.chosen_index == '0 && rsp.new_count == '0))
    else $error("response without grant carries nonzero fields");

  // saturating increment never yields zero
  a_grant_count: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.granted) |-> (rsp.new_count != '0))
    else $error("granted worker reports zero use count");
endmodule

bind least_used_idle_worker_dispatch_top luiwd_chk u_chk (
  .clk (clk),
  .rst (rst),
  .req (req),
  .rsp (rsp)
);

FILE: test/least_used_idle_worker_dispatch_top_tb.sv
// self-checking testbench for the least-used idle worker dispatcher
`timescale 1ns / 1ps

module least_used_idle_worker_dispatch_top_tb;
  import luiwd_pkg::*;

  localparam int NUM_W       = NUM_WORKERS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SEGMENTS    = 16;
  localparam int SEG_ITEMS   = 28;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic                 op;
    logic [IDX_OUT_W-1:0] idx;
    logic [ACT_W-1:0]     cfg;
    bit                   typed;
    res_t                 want;
  } dir_row_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [ACT_W-1:0] cfg_wdata;

  luiwd_req_if req_ch();
  luiwd_rsp_if rsp_ch();

  least_used_idle_worker_dispatch_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // shadow of the dispatcher state
  logic               busy_model [NUM_W];
  logic [COUNT_W-1:0] uses_model [NUM_W];
  logic [ACT_W-1:0]   pool_model;

  res_t     grant_expected[$];
  dir_row_t dir_rows[$];

  int mismatches = 0;
  int cycles     = 0;
  int send_idle  = 0;
  int recv_stall = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic res_t predict_dispatch(input logic op, input logic [IDX_OUT_W-1:0] idx);
    res_t               r;
    int                 lim;
    int                 pick;
    bit                 found;
    logic [COUNT_W-1:0] best;
    r     = '0;
    pick  = 0;
    found = 1'b0;
    best  = '0;
    if (op == OP_RELEASE) begin
      busy_model[idx] = 1'b0;
      return r;
    end
    lim = (int'(pool_model) > NUM_W) ? NUM_W : int'(pool_model);
    // <= keeps the highest index among equal counts
    for (int i = 0; i < lim; i++) begin
      if (!busy_model[i] && (!found || uses_model[i] <= best)) begin
        best  = uses_model[i];
        pick  = i;
        found = 1'b1;
      end
    end
    if (!found) return r;
    busy_model[pick] = 1'b1;
    if (uses_model[pick] != COUNT_MAX) uses_model[pick] = uses_model[pick] + 1'b1;
    r.granted      = 1'b1;
    r.chosen_index = pick[IDX_OUT_W-1:0];
    r.new_count    = uses_model[pick];
    return r;
  endfunction

  function automatic dir_row_t mk_row(input row_kind_t kind, input logic op,
                                      input logic [IDX_OUT_W-1:0] idx,
                                      input logic [ACT_W-1:0] cfg, input bit typed,
                                      input logic g, input logic [IDX_OUT_W-1:0] ci,
                                      input logic [COUNT_W-1:0] nc);
    dir_row_t d;
    d.kind              = kind;
    d.op                = op;
    d.idx               = idx;
    d.cfg               = cfg;
    d.typed             = typed;
    d.want.granted      = g;
    d.want.chosen_index = ci;
    d.want.new_count    = nc;
    return d;
  endfunction

  task automatic send_req(input logic op, input logic [IDX_OUT_W-1:0] idx, input bit typed,
                          input res_t want);
    res_t p;
    if (send_idle != 0 && $urandom_range(0, 99) < send_idle) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    req_ch.valid         <= 1'b1;
    req_ch.op            <= op;
    req_ch.release_index <= idx;
    do @(posedge clk); while (!req_ch.ready);
    p = predict_dispatch(op, idx);
    grant_expected.push_back(typed ? want : p);
  endtask

  // config only changes once every pending response is back
  task automatic drain_and_config(input logic [ACT_W-1:0] v);
    req_ch.valid <= 1'b0;
    while (grant_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    pool_model = v;
    cfg_we <= 1'b0;
  endtask

  task automatic random_req();
    logic [IDX_OUT_W-1:0] busy_list[$];
    logic [IDX_OUT_W-1:0] idx;
    res_t                 none;
    none = '0;
    if ($urandom_range(0, 99) < 55) begin
      send_req(OP_DISPATCH, IDX_OUT_W'($urandom_range(0, 15)), 1'b0, none);
    end else begin
      for (int i = 0; i < NUM_W; i++) if (busy_model[i]) busy_list.push_back(IDX_OUT_W'(i));
      // mostly free a worker that is actually busy
      if (busy_list.size() != 0 && $urandom_range(0, 99) < 70)
        idx = busy_list[$urandom_range(0, busy_list.size() - 1)];
      else
        idx = IDX_OUT_W'($urandom_range(0, 15));
      send_req(OP_RELEASE, idx, 1'b0, none);
    end
  endtask

  always @(posedge clk) begin : rsp_monitor
    res_t want;
    if (rst) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (grant_expected.size() == 0) begin
        $error("response with no request pending: granted %0d chosen_index %0d new_count %0d",
               rsp_ch.granted, rsp_ch.chosen_index, rsp_ch.new_count);
        mismatches++;
      end else begin
        want = grant_expected.pop_front();
        if (rsp_ch.granted !== want.granted) begin
          $error("granted: expected %0d actual %0d", want.granted, rsp_ch.granted);
          mismatches++;
        end
        if (rsp_ch.chosen_index !== want.chosen_index) begin
          $error("chosen_index: expected %0d actual %0d", want.chosen_index,
                 rsp_ch.chosen_index);
          mismatches++;
        end
        if (rsp_ch.new_count !== want.new_count) begin
          $error("new_count: expected %0d actual %0d", want.new_count, rsp_ch.new_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("least_used_idle_worker_dispatch_top_tb: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    logic [ACT_W-1:0] v;
    int               phase;
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    req_ch.valid         <= 1'b0;
    req_ch.op            <= OP_DISPATCH;
    req_ch.release_index <= '0;
    for (int i = 0; i < NUM_W; i++) begin
      busy_model[i] = 1'b0;
      uses_model[i] = '0;
    end
    pool_model = ACT_RESET;

    // directed table
    dir_rows.push_back(mk_row(ROW_REQ, OP_DISPATCH, 4'd0, 5'd0, 1'b1, 1'b1, 4'd15, 32'd1));
    dir_rows.push_back(mk_row(ROW_REQ, OP_DISPATCH, 4'd0, 5'd0, 1'b1, 1'b1, 4'd14, 32'd1));
    dir_rows.push_back(mk_row(ROW_REQ, OP_RELEASE, 4'd15, 5'd0, 1'b1, 1'b0, 4'd0, 32'd0));
    // release of a worker that is already idle
    dir_rows.push_back(mk_row(ROW_REQ, OP_RELEASE, 4'd0, 5'd0, 1'b1, 1'b0, 4'd0, 32'd0));
    dir_rows.push_back(mk_row(ROW_REQ, OP_DISPATCH, 4'd0, 5'd0, 1'b0, 1'b0, 4'd0, 32'd0));
    dir_rows.push_back(mk_row(ROW_CFG, OP_DISPATCH, 4'd0, 5'd1, 1'b0, 1'b0, 4'd0, 32'd0));
    dir_rows.push_back(mk_row(ROW_REQ, OP_DISPATCH, 4'd0, 5'd0, 1'b1, 1'b1, 4'd0, 32'd1));
    // pool of one is now fully busy
    dir_rows.push_back(mk_row(ROW_REQ, OP_DISPATCH, 4'd0, 5'd0, 1'b1, 1'b0, 4'd0, 32'd0));
    // release outside the active range
    dir_rows.push_back(mk_row(ROW_REQ, OP_RELEASE, 4'd14, 5'd0, 1'b1, 1'b0, 4'd0, 32'd0));
    dir_rows.push_back(mk_row(ROW_CFG, OP_DISPATCH, 4'd0, 5'd0, 1'b0, 1'b0, 4'd0, 32'd0));
    // empty pool never grants
    dir_rows.push_back(mk_row(ROW_REQ, OP_DISPATCH, 4'd0, 5'd0, 1'b1, 1'b0, 4'd0, 32'd0));
    dir_rows.push_back(mk_row(ROW_REQ, OP_RELEASE, 4'd0, 5'd0, 1'b1, 1'b0, 4'd0, 32'd0));
    // oversized pool scans all workers
    dir_rows.push_back(mk_row(ROW_CFG, OP_DISPATCH, 4'd0, 5'd31, 1'b0, 1'b0, 4'd0, 32'd0));
    for (int i = 0; i < 10; i++)
      dir_rows.push_back(mk_row(ROW_REQ, OP_DISPATCH, 4'd0, 5'd0, 1'b0, 1'b0, 4'd0, 32'd0));
    dir_rows.push_back(mk_row(ROW_REQ, OP_RELEASE, 4'd15, 5'd0, 1'b1, 1'b0, 4'd0, 32'd0));
    dir_rows.push_back(mk_row(ROW_REQ, OP_RELEASE, 4'd5, 5'd0, 1'b1, 1'b0, 4'd0, 32'd0));
    dir_rows.push_back(mk_row(ROW_REQ, OP_RELEASE, 4'd10, 5'd0, 1'b1, 1'b0, 4'd0, 32'd0));
    dir_rows.push_back(mk_row(ROW_CFG, OP_DISPATCH, 4'd0, 5'd16, 1'b0, 1'b0, 4'd0, 32'd0));
    dir_rows.push_back(mk_row(ROW_REQ, OP_DISPATCH, 4'd0, 5'd0, 1'b0, 1'b0, 4'd0, 32'd0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) drain_and_config(dir_rows[i].cfg);
      else send_req(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].typed, dir_rows[i].want);
    end

    // random part: four idling phases, each over several pool sizes
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      phase = seg / (SEGMENTS / 4);
      case (phase)
        0: begin
          send_idle  = 0;
          recv_stall = 0;
        end
        1: begin
          send_idle  = 68;
          recv_stall = 0;
        end
        2: begin
          send_idle  = 0;
          recv_stall = 68;
        end
        default: begin
          send_idle  = 27;
          recv_stall = 27;
        end
      endcase
      case ($urandom_range(0, 7))
        0: v = 5'd1;
        1: v = 5'd16;
        2: v = 5'd31;
        3: v = 5'd0;
        4: v = ACT_W'($urandom_range(17, 31));
        default: v = ACT_W'($urandom_range(2, 15));
      endcase
      drain_and_config(v);
      repeat (SEG_ITEMS) random_req();
    end

    req_ch.valid <= 1'b0;
    while (grant_expected.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("least_used_idle_worker_dispatch_top_tb: done, clean");
    end else begin
      $display("least_used_idle_worker_dispatch_top_tb: done, errors");
    end
    $finish;
  end

endmodule
